### design/rle_image_decoder_assert.svh
// assertion macros for the run-length image decoder
`ifndef RLE_IMAGE_DECODER_ASSERT_SVH
`define RLE_IMAGE_DECODER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define RID_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rid: implication check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define RID_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rid: next-cycle check failed");

`endif

### design/rid_pkg.sv
// shared types and constants of the run-length image decoder
`timescale 1ns / 1ps

package rid_pkg;

    localparam logic [7:0] RUN_FIRST_CODE = 8'hC1;
    localparam logic [7:0] RUN_BASE       = 8'hC0;

    localparam logic [15:0] MAX_WIDTH_RESET  = 16'd640;
    localparam logic [15:0] MAX_HEIGHT_RESET = 16'd480;

    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic CFG_MAX_WIDTH  = 1'b0;
    localparam logic CFG_MAX_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_PIXEL      = 3'd0,
        ST_DONE       = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_OVERRUN    = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_TRAILING   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        HDR_W_LO = 3'd0,
        HDR_W_HI = 3'd1,
        HDR_H_LO = 3'd2,
        HDR_H_HI = 3'd3,
        HDR_BODY = 3'd4
    } t_hdr_pos;

    // one command for the back end: count results of value, status on the last
    typedef struct packed {
        logic [7:0] value;
        logic [5:0] count;
        t_status    status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_stat;

endpackage

### design/rid_in_if.sv
// input byte channel of the run-length image decoder
`timescale 1ns / 1ps

interface rid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### design/rid_out_if.sv
// result channel of the run-length image decoder
`timescale 1ns / 1ps

interface rid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic [2:0] status;
    logic       run_end;

    modport source (output valid, output pixel, output status, output run_end, input ready);
    modport sink   (input valid, input pixel, input status, input run_end, output ready);
endinterface

### design/rid_queue.sv
// command queue between the byte parser and the pixel expander
`timescale 1ns / 1ps

module rid_queue #(
    parameter int DEPTH = rid_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rid_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output rid_pkg::t_q_stat o_stat,
    output rid_pkg::t_cmd   o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rid_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_stat.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### design/rid_front.sv
// byte parser: header, run codes, pixel accounting and error handling
`timescale 1ns / 1ps

module rid_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rid_in_if.sink        i_in,
    input  logic [15:0]   i_max_width,
    input  logic [15:0]   i_max_height,
    input  logic          i_full,
    output logic          o_push,
    output rid_pkg::t_cmd o_cmd
);

    rid_pkg::t_hdr_pos r_hdr_pos, n_hdr_pos;
    logic [15:0] r_width, n_width;
    logic [7:0]  r_height_lo, n_height_lo;
    logic [31:0] r_pixels_left, n_pixels_left;
    logic        r_run_wait, n_run_wait;
    logic [5:0]  r_run_len, n_run_len;
    logic        r_err, n_err;

    logic        accept;
    logic [7:0]  b;
    logic        fin;
    logic [15:0] height;
    logic        bad_hdr;
    logic [31:0] area;
    logic [5:0]  count;
    logic        do_emit;
    logic        rearm;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign fin        = i_in.final_byte;
    assign height     = {b, r_height_lo};
    assign area       = r_width * height;
    assign bad_hdr    = (r_width == '0) || (height == '0) ||
                        (r_width > i_max_width) || (height > i_max_height);

    always_comb begin
        n_hdr_pos     = r_hdr_pos;
        n_width       = r_width;
        n_height_lo   = r_height_lo;
        n_pixels_left = r_pixels_left;
        n_run_wait    = r_run_wait;
        n_run_len     = r_run_len;
        n_err         = r_err;
        o_push        = 1'b0;
        o_cmd.value   = '0;
        o_cmd.count   = 6'd1;
        o_cmd.status  = rid_pkg::ST_PIXEL;
        count         = 6'd1;
        do_emit       = 1'b0;
        rearm         = 1'b0;

        if (accept) begin
            if (r_err) begin
                rearm = fin;
            end else if (r_hdr_pos != rid_pkg::HDR_BODY) begin
                case (r_hdr_pos)
                    rid_pkg::HDR_W_LO: begin
                        n_width   = {8'd0, b};
                        n_hdr_pos = rid_pkg::HDR_W_HI;
                    end
                    rid_pkg::HDR_W_HI: begin
                        n_width   = {b, r_width[7:0]};
                        n_hdr_pos = rid_pkg::HDR_H_LO;
                    end
                    rid_pkg::HDR_H_LO: begin
                        n_height_lo = b;
                        n_hdr_pos   = rid_pkg::HDR_H_HI;
                    end
                    default: begin
                        n_hdr_pos = rid_pkg::HDR_BODY;
                    end
                endcase
                if (r_hdr_pos == rid_pkg::HDR_H_HI && bad_hdr) begin
                    o_push       = 1'b1;
                    o_cmd.status = rid_pkg::ST_BAD_HEADER;
                    rearm        = fin;
                    n_err        = !fin;
                end else begin
                    if (r_hdr_pos == rid_pkg::HDR_H_HI) begin
                        n_pixels_left = area;
                    end
                    if (fin) begin
                        o_push       = 1'b1;
                        o_cmd.status = rid_pkg::ST_TRUNCATED;
                        rearm        = 1'b1;
                    end
                end
            end else if (r_pixels_left == '0) begin
                o_push       = 1'b1;
                o_cmd.status = rid_pkg::ST_TRAILING;
                rearm        = fin;
                n_err        = !fin;
            end else if (r_run_wait) begin
                n_run_wait = 1'b0;
                n_run_len  = '0;
                count      = r_run_len;
                if ({26'd0, r_run_len} > r_pixels_left) begin
                    o_push       = 1'b1;
                    o_cmd.status = rid_pkg::ST_OVERRUN;
                    rearm        = fin;
                    n_err        = !fin;
                end else begin
                    do_emit = 1'b1;
                end
            end else if (b >= rid_pkg::RUN_FIRST_CODE) begin
                if (fin) begin
                    o_push       = 1'b1;
                    o_cmd.status = rid_pkg::ST_TRUNCATED;
                    rearm        = 1'b1;
                end else begin
                    n_run_wait = 1'b1;
                    n_run_len  = 6'(b - rid_pkg::RUN_BASE);
                end
            end else begin
                do_emit = 1'b1;
            end

            if (do_emit) begin
                o_push = 1'b1;
                if (fin && ({26'd0, count} != r_pixels_left)) begin
                    o_cmd.status = rid_pkg::ST_TRUNCATED;
                    rearm        = 1'b1;
                end else begin
                    n_pixels_left = r_pixels_left - {26'd0, count};
                    o_cmd.value   = b;
                    o_cmd.count   = count;
                    o_cmd.status  = fin ? rid_pkg::ST_DONE : rid_pkg::ST_PIXEL;
                    rearm         = fin;
                end
            end

            // back to waiting for a new header
            if (rearm) begin
                n_hdr_pos     = rid_pkg::HDR_W_LO;
                n_width       = '0;
                n_height_lo   = '0;
                n_pixels_left = '0;
                n_run_wait    = 1'b0;
                n_run_len     = '0;
                n_err         = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos     <= rid_pkg::HDR_W_LO;
            r_width       <= '0;
            r_height_lo   <= '0;
            r_pixels_left <= '0;
            r_run_wait    <= 1'b0;
            r_run_len     <= '0;
            r_err         <= 1'b0;
        end else begin
            r_hdr_pos     <= n_hdr_pos;
            r_width       <= n_width;
            r_height_lo   <= n_height_lo;
            r_pixels_left <= n_pixels_left;
            r_run_wait    <= n_run_wait;
            r_run_len     <= n_run_len;
            r_err         <= n_err;
        end
    end

endmodule

### design/rid_back.sv
// pixel expander: turns queued commands into result words
`timescale 1ns / 1ps

module rid_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rid_pkg::t_q_stat   i_q_stat,
    input  rid_pkg::t_cmd      i_cmd,
    output rid_pkg::t_back_stat o_stat,
    rid_out_if.source          o_out
);

    logic            r_busy;
    logic [7:0]      r_value;
    logic [5:0]      r_cnt;
    rid_pkg::t_status r_status;

    logic            r_out_valid;
    logic [7:0]      r_out_pixel;
    rid_pkg::t_status r_out_status;
    logic            r_out_end;

    logic emit;
    logic last;
    logic pop;

    assign emit = r_busy && (!r_out_valid || o_out.ready);
    assign last = (r_cnt == 6'd1);
    // take the next command when idle, or in the cycle the current one gives its last word
    assign pop  = i_q_stat.valid && (!r_busy || (emit && last));

    assign o_stat.busy = r_busy;
    assign o_stat.pop  = pop;

    assign o_out.valid   = r_out_valid;
    assign o_out.pixel   = r_out_pixel;
    assign o_out.status  = r_out_status;
    assign o_out.run_end = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (pop) begin
            r_busy <= 1'b1;
        end else if (emit && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_value  <= i_cmd.value;
            r_cnt    <= i_cmd.count;
            r_status <= i_cmd.status;
        end else if (emit) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pixel  <= r_value;
            r_out_status <= last ? r_status : rid_pkg::ST_PIXEL;
            r_out_end    <= last;
        end
    end

endmodule

### design/rle_image_decoder.sv
// top level of the run-length image decoder
//
//  channel   dir   word                              handshake
//  i_in      in    data_byte[7:0], final_byte        valid / ready
//  o_out     out   pixel[7:0], status[2:0], run_end  valid / ready
//  i_cfg_*   in    index[0], data[15:0]              write enable, no wait
//
// the parser takes one byte per cycle while the command queue has room
// each queued command gives 1 to 63 result words, one per cycle from the expander while o_out takes them
// so a literal byte gives one result word, a run gives as many words as its length
// stalls on o_out back up through the queue to i_in.ready
// synchronous active-low reset; limits reset to 640 x 480
`timescale 1ns / 1ps
`include "rle_image_decoder_assert.svh"

module rle_image_decoder #(
    parameter int QUEUE_DEPTH = rid_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rid_in_if.sink      i_in,
    rid_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_max_width;
    logic [15:0] r_max_height;

    logic                push;
    rid_pkg::t_cmd       push_cmd;
    rid_pkg::t_cmd       head_cmd;
    rid_pkg::t_q_stat    q_stat;
    rid_pkg::t_back_stat back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width  <= rid_pkg::MAX_WIDTH_RESET;
            r_max_height <= rid_pkg::MAX_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rid_pkg::CFG_MAX_WIDTH:  r_max_width  <= i_cfg_data;
                rid_pkg::CFG_MAX_HEIGHT: r_max_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rid_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_max_width  (r_max_width),
        .i_max_height (r_max_height),
        .i_full       (q_stat.full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (back_stat.pop),
        .o_stat  (q_stat),
        .o_cmd   (head_cmd)
    );

    rid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (head_cmd),
        .o_stat   (back_stat),
        .o_out    (o_out)
    );

    // a full queue must hold off the byte side
    `RID_ASSERT_IMP(a_full_blocks_input, q_stat.full, !i_in.ready)
    // error and completion words always close the word group of their byte
    `RID_ASSERT_IMP(a_status_closes_run, o_out.valid && (o_out.status != rid_pkg::ST_PIXEL), o_out.run_end)
    // nothing queued and nothing in flight means no fresh word next cycle
    `RID_ASSERT_NXT(a_idle_no_word, !back_stat.busy && !q_stat.valid && o_out.ready, !o_out.valid)

endmodule
